[hdl/rfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rfd_pkg;

    // Default address width of the framebuffer.
    localparam int ADDR_BITS_DEFAULT = 16;

    // Reset values of the configuration registers.
    localparam logic [15:0] LINE_WIDTH_RESET       = 16'd320;
    localparam logic [15:0] KEY_FRAME_HEIGHT_RESET = 16'd200;

    // Configuration register indexes (address bit 2).
    localparam logic REG_LINE_WIDTH       = 1'b0;
    localparam logic REG_KEY_FRAME_HEIGHT = 1'b1;

    // Request kinds carried with each byte.
    typedef enum logic [1:0] {
        REQ_KEY_START   = 2'd0,
        REQ_DELTA_START = 2'd1,
        REQ_DATA        = 2'd2,
        REQ_NONE        = 2'd3
    } req_kind_t;

    // One decoded result item.
    typedef struct packed {
        logic        valid;
        logic        write_valid;
        logic [15:0] run_address;
        logic [7:0]  run_length;
        logic [7:0]  run_value;
        logic        frame_done;
        logic        protocol_error;
    } rfd_result_t;

endpackage

`default_nettype wire

[hdl/rle_frame_decoder_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Run-length frame decoder. Each input transfer carries a request kind on
// s_tuser (start key frame, start delta frame, data byte) and a compressed
// byte on s_tdata; each byte may produce one output transfer holding a
// framebuffer run write, an end-of-frame mark on m_tlast, or a protocol error
// flag. The block takes one input transfer per clock cycle while its output
// register is empty or drained; the whole decode step for a byte is one
// update of the decoder state. Results wait in one output register refilled
// in the same cycle it is taken. line_width (address 0), key_frame_height
// (address 4): write over APB only while the decoder is idle; not enforced.
module rle_frame_decoder_top
    import rfd_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] run_address, [23:16] run_length,
                                        // [31:24] run_value
    output logic [1:0]       m_tuser,   // [0] write_valid, [1] protocol_error
    output logic             m_tlast,   // frame_done

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [15:0] line_width_reg;
    logic [15:0] key_frame_height_reg;
    logic        cfg_write;
    logic        step;
    rfd_result_t result;
    rfd_result_t out_reg;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg       <= LINE_WIDTH_RESET;
            key_frame_height_reg <= KEY_FRAME_HEIGHT_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_LINE_WIDTH:       line_width_reg       <= pwdata[15:0];
                REG_KEY_FRAME_HEIGHT: key_frame_height_reg <= pwdata[15:0];
                default:              line_width_reg       <= line_width_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_LINE_WIDTH:       prdata = {16'd0, line_width_reg};
            REG_KEY_FRAME_HEIGHT: prdata = {16'd0, key_frame_height_reg};
            default:              prdata = '0;
        endcase
    end

    // Accept a byte whenever the output register is empty or being drained.
    assign s_tready = !out_reg.valid || m_tready;
    assign step     = s_tvalid && s_tready;

    rfd_core #(
        .ADDR_BITS(ADDR_BITS)
    ) u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step             (step),
        .req_type         (s_tuser),
        .data_byte        (s_tdata),
        .line_width       (line_width_reg),
        .key_frame_height (key_frame_height_reg),
        .result           (result)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg <= '0;
        end else if (step && result.valid) begin
            out_reg <= result;
        end else if (m_tready) begin
            out_reg.valid <= 1'b0;
        end
    end

    assign m_tvalid = out_reg.valid;
    assign m_tdata  = {out_reg.run_value, out_reg.run_length, out_reg.run_address};
    assign m_tuser  = {out_reg.protocol_error, out_reg.write_valid};
    assign m_tlast  = out_reg.frame_done;

endmodule

`default_nettype wire

[hdl/rfd_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module rfd_core
    import rfd_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  data_byte,
    input  wire logic [15:0] line_width,
    input  wire logic [15:0] key_frame_height,
    output rfd_result_t      result
);

    // Decoder phases.
    localparam logic [3:0] PH_IDLE     = 4'd0;
    localparam logic [3:0] PH_HDR0     = 4'd1;
    localparam logic [3:0] PH_HDR1     = 4'd2;
    localparam logic [3:0] PH_HDR2     = 4'd3;
    localparam logic [3:0] PH_HDR3     = 4'd4;
    localparam logic [3:0] PH_SEGCOUNT = 4'd5;
    localparam logic [3:0] PH_SKIP     = 4'd6;
    localparam logic [3:0] PH_RUN      = 4'd7;
    localparam logic [3:0] PH_COLOR    = 4'd8;
    localparam logic [3:0] PH_COPY     = 4'd9;

    logic [3:0]           phase_reg, phase_next;
    logic                 is_delta_reg, is_delta_next;
    logic [ADDR_BITS-1:0] write_pointer_reg, write_pointer_next;
    logic [ADDR_BITS-1:0] line_base_reg, line_base_next;
    logic [15:0]          lines_left_reg, lines_left_next;
    logic [6:0]           segments_left_reg, segments_left_next;
    logic [7:0]           run_left_reg, run_left_next;
    logic                 copy_mode_reg, copy_mode_next;
    logic [7:0]           header_low_reg, header_low_next;

    logic [15:0]          header_word;
    logic [31:0]          start_product;
    logic [ADDR_BITS-1:0] next_line_base;
    logic [15:0]          lines_dec;
    logic [6:0]           segments_dec;
    logic [7:0]           run_dec;
    logic [7:0]           byte_neg;
    logic                 finish_segment;
    logic                 finish_line;

    // Shared arithmetic for the header and line bookkeeping.
    assign header_word    = {data_byte, header_low_reg};
    assign start_product  = header_word * line_width;
    assign next_line_base = line_base_reg + ADDR_BITS'(line_width);
    assign lines_dec      = lines_left_reg - 16'd1;
    assign segments_dec   = segments_left_reg - 7'd1;
    assign run_dec        = run_left_reg - 8'd1;
    assign byte_neg       = 8'd0 - data_byte;

    // Next state and result for the byte being taken.
    always_comb begin
        phase_next         = phase_reg;
        is_delta_next      = is_delta_reg;
        write_pointer_next = write_pointer_reg;
        line_base_next     = line_base_reg;
        lines_left_next    = lines_left_reg;
        segments_left_next = segments_left_reg;
        run_left_next      = run_left_reg;
        copy_mode_next     = copy_mode_reg;
        header_low_next    = header_low_reg;
        finish_segment     = 1'b0;
        finish_line        = 1'b0;
        result             = '0;

        unique case (req_type)
            REQ_KEY_START: begin
                is_delta_next      = 1'b0;
                line_base_next     = '0;
                write_pointer_next = '0;
                lines_left_next    = (key_frame_height == 16'd0) ? 16'd1 : key_frame_height;
                segments_left_next = '0;
                run_left_next      = '0;
                copy_mode_next     = 1'b0;
                phase_next         = PH_SEGCOUNT;
            end
            REQ_DELTA_START: begin
                is_delta_next      = 1'b1;
                segments_left_next = '0;
                run_left_next      = '0;
                copy_mode_next     = 1'b0;
                phase_next         = PH_HDR0;
            end
            REQ_NONE: begin
                phase_next = phase_reg;
            end
            REQ_DATA: begin
                unique case (phase_reg)
                    PH_HDR0: begin
                        header_low_next = data_byte;
                        phase_next      = PH_HDR1;
                    end
                    PH_HDR2: begin
                        header_low_next = data_byte;
                        phase_next      = PH_HDR3;
                    end
                    PH_HDR1: begin
                        // Starting line times width, wrapped at 16 bits.
                        line_base_next     = ADDR_BITS'(start_product[15:0]);
                        write_pointer_next = ADDR_BITS'(start_product[15:0]);
                        phase_next         = PH_HDR2;
                    end
                    PH_HDR3: begin
                        // A zero or negative line count decodes one line.
                        if (header_word == 16'd0 || header_word[15]) begin
                            lines_left_next = 16'd1;
                        end else begin
                            lines_left_next = header_word;
                        end
                        phase_next = PH_SEGCOUNT;
                    end
                    PH_SEGCOUNT: begin
                        if (data_byte == 8'd0 || data_byte[7]) begin
                            finish_line = 1'b1;
                        end else begin
                            segments_left_next = data_byte[6:0];
                            phase_next         = is_delta_reg ? PH_SKIP : PH_RUN;
                        end
                    end
                    PH_SKIP: begin
                        write_pointer_next = write_pointer_reg + ADDR_BITS'(data_byte);
                        phase_next         = PH_RUN;
                    end
                    PH_RUN: begin
                        // Delta frames copy on a positive byte, key frames on a negative one.
                        if (is_delta_reg) begin
                            if (data_byte != 8'd0 && !data_byte[7]) begin
                                copy_mode_next = 1'b1;
                                run_left_next  = data_byte;
                                phase_next     = PH_COPY;
                            end else begin
                                copy_mode_next = 1'b0;
                                run_left_next  = byte_neg;
                                phase_next     = PH_COLOR;
                            end
                        end else begin
                            if (data_byte[7]) begin
                                copy_mode_next = 1'b1;
                                run_left_next  = byte_neg;
                                phase_next     = PH_COPY;
                            end else begin
                                copy_mode_next = 1'b0;
                                run_left_next  = data_byte;
                                phase_next     = PH_COLOR;
                            end
                        end
                    end
                    PH_COLOR: begin
                        if (run_left_reg != 8'd0) begin
                            result.write_valid = 1'b1;
                            result.run_address = write_pointer_reg[15:0];
                            result.run_length  = run_left_reg;
                            result.run_value   = data_byte;
                            write_pointer_next = write_pointer_reg + ADDR_BITS'(run_left_reg);
                        end
                        run_left_next  = '0;
                        finish_segment = 1'b1;
                    end
                    PH_COPY: begin
                        result.write_valid = 1'b1;
                        result.run_address = write_pointer_reg[15:0];
                        result.run_length  = 8'd1;
                        result.run_value   = data_byte;
                        write_pointer_next = write_pointer_reg + ADDR_BITS'(1);
                        run_left_next      = run_dec;
                        finish_segment     = (run_dec == 8'd0);
                    end
                    default: begin
                        // A data byte with no frame in progress.
                        phase_next            = PH_IDLE;
                        result.protocol_error = 1'b1;
                    end
                endcase
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase

        // End of a segment, possibly closing the line.
        if (finish_segment) begin
            segments_left_next = segments_dec;
            if (segments_dec == 7'd0) begin
                finish_line = 1'b1;
            end else begin
                phase_next = is_delta_reg ? PH_SKIP : PH_RUN;
            end
        end

        // End of a line, possibly closing the frame.
        if (finish_line) begin
            line_base_next     = next_line_base;
            write_pointer_next = next_line_base;
            lines_left_next    = lines_dec;
            if (lines_dec == 16'd0) begin
                phase_next        = PH_IDLE;
                result.frame_done = 1'b1;
            end else begin
                phase_next = PH_SEGCOUNT;
            end
        end

        result.valid = result.write_valid | result.frame_done | result.protocol_error;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_IDLE;
            is_delta_reg      <= 1'b0;
            write_pointer_reg <= '0;
            line_base_reg     <= '0;
            lines_left_reg    <= '0;
            segments_left_reg <= '0;
            run_left_reg      <= '0;
            copy_mode_reg     <= 1'b0;
            header_low_reg    <= '0;
        end else if (step) begin
            phase_reg         <= phase_next;
            is_delta_reg      <= is_delta_next;
            write_pointer_reg <= write_pointer_next;
            line_base_reg     <= line_base_next;
            lines_left_reg    <= lines_left_next;
            segments_left_reg <= segments_left_next;
            run_left_reg      <= run_left_next;
            copy_mode_reg     <= copy_mode_next;
            header_low_reg    <= header_low_next;
        end
    end

endmodule

`default_nettype wire
